[sv/waveform_frame_cell_offset_correct_assert.svh]
// ============================================================================
// Assertion macros for the cell offset correction block
// Clocked assertion shorthands on clk, disabled while rst_n is low.
// ============================================================================
`ifndef WAVEFORM_FRAME_CELL_OFFSET_CORRECT_ASSERT_SVH
`define WAVEFORM_FRAME_CELL_OFFSET_CORRECT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WFCOC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WFCOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/wfcoc_pkg.sv]
// ============================================================================
// wfcoc_pkg
// Shared widths, command codes, defaults and record types.
// ============================================================================
package wfcoc_pkg;

    localparam int CELLS_DEF        = 1024;
    localparam int PACKETS_DEF      = 32;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int CHANNELS_DEF     = 16;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int BYTE_W    = 8;
    localparam int ROW_W     = 10;
    localparam int TCHAN_W   = 4;
    localparam int OFFSET_W  = 16;
    localparam int RAW_W     = 16;
    localparam int STOP_W    = 16;
    localparam int CHANNEL_W = 4;
    localparam int INDEX_W   = 10;
    localparam int VALUE_W   = 17;

    localparam int OFFSET_BIAS = 8192;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TABLE = 1'b1;

    typedef struct packed {
        logic [CHANNEL_W-1:0] out_channel;
        logic [INDEX_W-1:0]   sample_index;
        logic [RAW_W-1:0]     raw;
    } sample_t;

    typedef struct packed {
        sample_t                     smp;
        logic signed [OFFSET_W-1:0]  offset;
    } entry_t;

endpackage

[sv/waveform_frame_cell_offset_correct.sv]
// Path: a completing sample byte passes the sample register and table read, the queue and
// the result register to the result ports; an unpopped result keeps the next in the queue.
// Throughput: one transaction per cycle unless full; one table RAM read or write a cycle.
// Stop cell base rows settle via the prod, qc and base registers before the first sample.
// Reset (rst_n low, asynchronous) clears frame position, stop cells, queue and output.
// The correction table is not cleared; entries must be written before they are used.
// ============================================================================
// waveform_frame_cell_offset_correct
// Per-cell offset correction of digitizer frames with output channel remap.
// ============================================================================
`include "waveform_frame_cell_offset_correct_assert.svh"

module waveform_frame_cell_offset_correct #(
    parameter int CELLS        = wfcoc_pkg::CELLS_DEF,
    parameter int PACKETS      = wfcoc_pkg::PACKETS_DEF,
    parameter int HEADER_BYTES = wfcoc_pkg::HEADER_BYTES_DEF,
    parameter int CHANNELS     = wfcoc_pkg::CHANNELS_DEF,
    parameter int QUEUE_DEPTH  = wfcoc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  command,
    input  logic                                  frame_start,
    input  logic [wfcoc_pkg::BYTE_W-1:0]          frame_byte,
    input  logic [wfcoc_pkg::ROW_W-1:0]           table_row,
    input  logic [wfcoc_pkg::TCHAN_W-1:0]         table_channel,
    input  logic signed [wfcoc_pkg::OFFSET_W-1:0] table_offset,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [wfcoc_pkg::CHANNEL_W-1:0]       out_channel,
    output logic [wfcoc_pkg::INDEX_W-1:0]         sample_index,
    output logic [wfcoc_pkg::VALUE_W-1:0]         corrected_value
);

    localparam int CW        = $clog2(CELLS);
    localparam int TBL_DEPTH = CHANNELS << CW;
    localparam int AW        = $clog2(TBL_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);

    logic                               accept;
    logic                               table_accept;
    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic [wfcoc_pkg::OFFSET_W-1:0]     wr_data;
    logic                               rd_en;
    logic [AW-1:0]                      rd_addr;
    logic [wfcoc_pkg::OFFSET_W-1:0]     rd_data;
    logic                               smp_valid;
    wfcoc_pkg::sample_t                 smp;
    wfcoc_pkg::entry_t                  q_in;
    wfcoc_pkg::entry_t                  q_out;
    logic                               q_empty;
    logic                               q_pop;
    logic [CNT_W-1:0]                   q_count;
    logic [CNT_W:0]                     occupancy;

    // hold off new transactions while the lookup in flight could overrun the queue
    assign occupancy    = (CNT_W+1)'(q_count) + (CNT_W+1)'(smp_valid);
    assign full         = (occupancy >= (CNT_W+1)'(QUEUE_DEPTH));
    assign accept       = push && !full;
    assign table_accept = accept && (command == wfcoc_pkg::CMD_TABLE);

    wfcoc_front #(
        .CELLS        (CELLS),
        .PACKETS      (PACKETS),
        .HEADER_BYTES (HEADER_BYTES),
        .CHANNELS     (CHANNELS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .command       (command),
        .frame_start   (frame_start),
        .frame_byte    (frame_byte),
        .table_row     (table_row),
        .table_channel (table_channel),
        .table_offset  (table_offset),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .smp_valid     (smp_valid),
        .smp           (smp)
    );

    wfcoc_ram #(
        .WIDTH (wfcoc_pkg::OFFSET_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign q_in.smp    = smp;
    assign q_in.offset = $signed(rd_data);

    wfcoc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (smp_valid),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty),
        .count     (q_count)
    );

    wfcoc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_data          (q_out),
        .q_pop           (q_pop),
        .pop             (pop),
        .empty           (empty),
        .out_channel     (out_channel),
        .sample_index    (sample_index),
        .corrected_value (corrected_value)
    );

    `WFCOC_ASSERT_NOW(a_queue_room, smp_valid, q_count < CNT_W'(QUEUE_DEPTH), "queue overrun")
    `WFCOC_ASSERT_NEXT(a_table_quiet, table_accept, !smp_valid, "table write produced a sample")
    `WFCOC_ASSERT_NOW(a_back_room, q_pop, empty || pop, "result register overrun")

endmodule

[sv/wfcoc_ram.sv]
// ============================================================================
// wfcoc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module wfcoc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/wfcoc_front.sv]
// ============================================================================
// wfcoc_front
// Frame tracking, stop cell capture, table write and lookup issue.
// ============================================================================
module wfcoc_front #(
    parameter int CELLS        = wfcoc_pkg::CELLS_DEF,
    parameter int PACKETS      = wfcoc_pkg::PACKETS_DEF,
    parameter int HEADER_BYTES = wfcoc_pkg::HEADER_BYTES_DEF,
    parameter int CHANNELS     = wfcoc_pkg::CHANNELS_DEF,
    localparam int CW          = $clog2(CELLS),
    localparam int AW          = $clog2(CHANNELS << CW)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic                                 command,
    input  logic                                 frame_start,
    input  logic [wfcoc_pkg::BYTE_W-1:0]         frame_byte,
    input  logic [wfcoc_pkg::ROW_W-1:0]          table_row,
    input  logic [wfcoc_pkg::TCHAN_W-1:0]        table_channel,
    input  logic signed [wfcoc_pkg::OFFSET_W-1:0] table_offset,
    output logic                                 wr_en,
    output logic [AW-1:0]                        wr_addr,
    output logic [wfcoc_pkg::OFFSET_W-1:0]       wr_data,
    output logic                                 rd_en,
    output logic [AW-1:0]                        rd_addr,
    output logic                                 smp_valid,
    output wfcoc_pkg::sample_t                   smp
);

    localparam int PKT_LEN    = HEADER_BYTES + CELLS;
    localparam int OFW        = $clog2(PKT_LEN);
    localparam int PW         = $clog2(PACKETS + 1);
    localparam int KW         = PW - 1;
    localparam int HALF       = CELLS / 2;
    localparam int EVEN_COUNT = (CHANNELS + 1) / 2;
    localparam int RMW        = 6;

    localparam int STOP_EVEN_HI = 4;
    localparam int STOP_EVEN_LO = 5;
    localparam int STOP_ODD_HI  = 6;
    localparam int STOP_ODD_LO  = 7;

    // base row reduction: (stop + 1) mod CELLS by reciprocal multiply
    localparam int     X_W        = wfcoc_pkg::STOP_W + 1;
    localparam int     RCP_SHIFT  = X_W + CW + 1;
    localparam int     RCP_W      = 20;
    localparam int     PROD_W     = X_W + RCP_W;
    localparam int     Q_W        = X_W - CW + 1;
    localparam longint RCP        = (longint'(1) << RCP_SHIFT) / CELLS + 1;

    logic [PW-1:0]  pkt_reg,  pkt_next;
    logic [OFW-1:0] off_reg,  off_next;
    logic [wfcoc_pkg::STOP_W-1:0] stop_reg [2];
    logic [wfcoc_pkg::STOP_W-1:0] stop_next [2];
    logic [wfcoc_pkg::BYTE_W-1:0] hold_reg, hold_next;
    logic                         smp_valid_reg;
    wfcoc_pkg::sample_t           smp_reg, smp_next;

    logic [X_W-1:0]    x1_reg   [2];
    logic [PROD_W-1:0] prod_reg [2];
    logic [X_W-1:0]    x2_reg   [2];
    logic [X_W-1:0]    qc_reg   [2];
    logic [CW-1:0]     base_reg [2];

    logic           frame_acc;
    logic           table_acc;
    logic [PW-1:0]  pkt_eff;
    logic [OFW-1:0] off_eff;
    logic           done;
    logic           in_hdr;
    logic [OFW-1:0] d;
    logic [KW-1:0]  k;
    logic [CW-1:0]  j;
    logic           is_sample;
    logic [CW-1:0]  base_sel;
    logic [CW:0]    row_sum;
    logic [CW-1:0]  row;
    logic [RMW-1:0] k_half;
    logic [RMW-1:0] remap;

    always_comb
    begin
        frame_acc = accept && (command == wfcoc_pkg::CMD_FRAME);
        table_acc = accept && (command == wfcoc_pkg::CMD_TABLE);
        pkt_eff   = frame_start ? '0 : pkt_reg;
        off_eff   = frame_start ? '0 : off_reg;
        done      = (pkt_eff == PW'(PACKETS));
        in_hdr    = (off_eff < OFW'(HEADER_BYTES));
        d         = off_eff - OFW'(HEADER_BYTES);
        k         = pkt_eff[PW-1:1];
        j         = CW'(d >> 1) + (pkt_eff[0] ? CW'(HALF) : CW'(0));
        is_sample = frame_acc && !done && !in_hdr && d[0] && (k < CHANNELS);

        base_sel = k[0] ? base_reg[1] : base_reg[0];
        row_sum  = (CW+1)'(base_sel) + (CW+1)'(j);
        row      = (row_sum >= (CW+1)'(CELLS)) ? CW'(row_sum - (CW+1)'(CELLS))
                                               : CW'(row_sum);

        k_half = RMW'(k >> 1);
        remap  = k[0] ? (RMW'(CHANNELS - 1) - k_half) : (RMW'(EVEN_COUNT - 1) - k_half);

        // advance the frame position; hold it once the frame is complete
        pkt_next = pkt_reg;
        off_next = off_reg;
        if (frame_acc && !done)
        begin
            if (off_eff == OFW'(PKT_LEN - 1))
            begin
                off_next = '0;
                pkt_next = pkt_eff + PW'(1);
            end
            else
            begin
                off_next = off_eff + OFW'(1);
                pkt_next = pkt_eff;
            end
        end

        stop_next[0] = stop_reg[0];
        stop_next[1] = stop_reg[1];
        if (frame_acc && !done && (pkt_eff == '0))
        begin
            case (off_eff)
                OFW'(STOP_EVEN_HI): stop_next[0] = {frame_byte, stop_reg[0][7:0]};
                OFW'(STOP_EVEN_LO): stop_next[0] = {stop_reg[0][15:8], frame_byte};
                OFW'(STOP_ODD_HI):  stop_next[1] = {frame_byte, stop_reg[1][7:0]};
                OFW'(STOP_ODD_LO):  stop_next[1] = {stop_reg[1][15:8], frame_byte};
                default:            ;
            endcase
        end

        hold_next = hold_reg;
        if (frame_acc)
        begin
            if (!done && !in_hdr && !d[0])
            begin
                hold_next = frame_byte;
            end
            else if (frame_start)
            begin
                hold_next = '0;
            end
        end

        smp_next.out_channel  = wfcoc_pkg::CHANNEL_W'(remap);
        smp_next.sample_index = wfcoc_pkg::INDEX_W'(j);
        smp_next.raw          = {hold_reg, frame_byte};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_reg       <= '0;
            off_reg       <= '0;
            stop_reg[0]   <= '0;
            stop_reg[1]   <= '0;
            hold_reg      <= '0;
            smp_valid_reg <= 1'b0;
        end
        else
        begin
            pkt_reg       <= pkt_next;
            off_reg       <= off_next;
            stop_reg[0]   <= stop_next[0];
            stop_reg[1]   <= stop_next[1];
            hold_reg      <= hold_next;
            smp_valid_reg <= is_sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_sample)
        begin
            smp_reg <= smp_next;
        end
        for (int l = 0; l < 2; l++)
        begin
            x1_reg[l]   <= X_W'(stop_reg[l]) + X_W'(1);
            prod_reg[l] <= PROD_W'(X_W'(stop_reg[l]) + X_W'(1)) * PROD_W'(RCP);
            x2_reg[l]   <= x1_reg[l];
            qc_reg[l]   <= X_W'(prod_reg[l][RCP_SHIFT +: Q_W] * CELLS);
            base_reg[l] <= CW'(x2_reg[l] - qc_reg[l]);
        end
    end

    assign wr_en   = table_acc && (table_row < CELLS) && (table_channel < CHANNELS);
    assign wr_addr = (AW'(table_channel) << CW) | AW'(CW'(table_row));
    assign wr_data = table_offset;
    assign rd_en   = is_sample;
    assign rd_addr = (AW'(k) << CW) | AW'(row);
    assign smp_valid = smp_valid_reg;
    assign smp       = smp_reg;

endmodule

[sv/wfcoc_queue.sv]
// ============================================================================
// wfcoc_queue
// Short register queue of looked-up samples between front and back.
// ============================================================================
module wfcoc_queue #(
    parameter int DEPTH = wfcoc_pkg::QUEUE_DEPTH_DEF,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wfcoc_pkg::entry_t   push_data,
    input  logic                pop,
    output wfcoc_pkg::entry_t   pop_data,
    output logic                empty,
    output logic [CNT_W-1:0]    count
);

    wfcoc_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

endmodule

[sv/wfcoc_back.sv]
// ============================================================================
// wfcoc_back
// Offset subtraction, bias and clamp into the result register.
// ============================================================================
module wfcoc_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  wfcoc_pkg::entry_t                   q_data,
    output logic                                q_pop,
    input  logic                                pop,
    output logic                                empty,
    output logic [wfcoc_pkg::CHANNEL_W-1:0]     out_channel,
    output logic [wfcoc_pkg::INDEX_W-1:0]       sample_index,
    output logic [wfcoc_pkg::VALUE_W-1:0]       corrected_value
);

    localparam int SUM_W = wfcoc_pkg::VALUE_W + 1;

    logic                               valid_reg, valid_next;
    logic [wfcoc_pkg::CHANNEL_W-1:0]    chan_reg;
    logic [wfcoc_pkg::INDEX_W-1:0]      index_reg;
    logic [wfcoc_pkg::VALUE_W-1:0]      value_reg, value_next;
    logic signed [SUM_W-1:0]            sum;
    logic                               take;

    always_comb
    begin
        take = !q_empty && (!valid_reg || pop);
        sum  = $signed({2'b00, q_data.smp.raw})
             - $signed({{2{q_data.offset[wfcoc_pkg::OFFSET_W-1]}}, q_data.offset})
             + $signed(SUM_W'(wfcoc_pkg::OFFSET_BIAS));
        // clamp negative results to zero
        value_next = sum[SUM_W-1] ? '0 : sum[wfcoc_pkg::VALUE_W-1:0];

        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            chan_reg  <= q_data.smp.out_channel;
            index_reg <= q_data.smp.sample_index;
            value_reg <= value_next;
        end
    end

    assign q_pop           = take;
    assign empty           = !valid_reg;
    assign out_channel     = chan_reg;
    assign sample_index    = index_reg;
    assign corrected_value = value_reg;

endmodule

[sim/waveform_frame_cell_offset_correct_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// waveform_frame_cell_offset_correct_tb
// Drives table writes and digitizer frame bytes through the push/full side,
// predicts every corrected sample and checks the pop/empty side in order.
// Covers table cells loaded just before their first use, directed corner
// samples, random frames with restarts, and random idling on both sides.
// ============================================================================
module waveform_frame_cell_offset_correct_tb;
    import wfcoc_pkg::*;

    localparam int PACKET_LEN   = HEADER_BYTES_DEF + CELLS_DEF;
    localparam int FRAME_LEN    = PACKETS_DEF * PACKET_LEN;
    localparam int HALF_CELLS   = CELLS_DEF / 2;
    localparam int EVEN_COUNT   = (CHANNELS_DEF + 1) / 2;
    localparam int TABLE_SIZE   = CHANNELS_DEF * CELLS_DEF;
    localparam int RANDOM_ITEMS = 1250;
    localparam int IDLE_PCT     = 23;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_CAP   = 100;

    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [INDEX_W-1:0]   index;
        logic [VALUE_W-1:0]   value;
    } corrected_sample_t;

    class cell_offset_tracker;
        int unsigned                frame_pos;
        logic [STOP_W-1:0]          stop_even;
        logic [STOP_W-1:0]          stop_odd;
        logic [BYTE_W-1:0]          high_hold;
        logic signed [OFFSET_W-1:0] offsets [TABLE_SIZE];
        bit                         loaded [TABLE_SIZE];
        corrected_sample_t          expected_samples [$];
        int                         mismatches;

        function new();
            frame_pos  = 0;
            stop_even  = '0;
            stop_odd   = '0;
            high_hold  = '0;
            mismatches = 0;
        endfunction

        function int waiting();
            return expected_samples.size();
        endfunction

        function bit is_loaded(logic [TCHAN_W-1:0] chan, logic [ROW_W-1:0] row);
            return loaded[chan * CELLS_DEF + row];
        endfunction

        // Apply one accepted transaction and queue the sample it completes, if any.
        function void take_transaction(logic cmd, logic start, logic [BYTE_W-1:0] data_byte,
                                       logic [ROW_W-1:0] row, logic [TCHAN_W-1:0] chan,
                                       logic signed [OFFSET_W-1:0] offset);
            int unsigned       pos;
            int unsigned       packet;
            int unsigned       in_packet;
            int unsigned       d;
            int unsigned       k;
            int unsigned       j;
            int                correction;
            int                value;
            logic [STOP_W-1:0] stop;
            logic [ROW_W-1:0]  read_row;
            corrected_sample_t s;
            if (cmd == CMD_TABLE)
            begin
                if (row < CELLS_DEF && chan < CHANNELS_DEF)
                begin
                    offsets[chan * CELLS_DEF + row] = offset;
                    loaded[chan * CELLS_DEF + row] = 1'b1;
                end
                return;
            end
            if (start)
            begin
                frame_pos = 0;
                high_hold = '0;
            end
            if (frame_pos >= FRAME_LEN)
                return;
            pos = frame_pos;
            frame_pos = pos + 1;
            packet = pos / PACKET_LEN;
            in_packet = pos % PACKET_LEN;
            if (in_packet < HEADER_BYTES_DEF)
            begin
                if (packet == 0)
                begin
                    case (in_packet)
                        4: stop_even[15:8] = data_byte;
                        5: stop_even[7:0]  = data_byte;
                        6: stop_odd[15:8]  = data_byte;
                        7: stop_odd[7:0]   = data_byte;
                        default: ;
                    endcase
                end
                return;
            end
            d = in_packet - HEADER_BYTES_DEF;
            if (d % 2 == 0)
            begin
                high_hold = data_byte;
                return;
            end
            k = packet / 2;
            j = d / 2 + (packet % 2) * HALF_CELLS;
            if (k >= CHANNELS_DEF || j >= CELLS_DEF)
                return;
            stop = (k % 2 == 1) ? stop_odd : stop_even;
            read_row = ROW_W'((stop + 1 + j) % CELLS_DEF);
            correction = offsets[k * CELLS_DEF + read_row];
            value = int'({high_hold, data_byte}) - correction + OFFSET_BIAS;
            if (value < 0)
                value = 0;
            // even native channels fill the low half of the outputs, odd ones the high half
            if (k % 2 == 0)
                s.channel = CHANNEL_W'(EVEN_COUNT - 1 - k / 2);
            else
                s.channel = CHANNEL_W'(CHANNELS_DEF - 1 - (k - 1) / 2);
            s.index = INDEX_W'(j);
            s.value = VALUE_W'(value);
            expected_samples.insert(expected_samples.size(), s);
        endfunction

        // Table cell that the sample under assembly will read, if the frame is in data.
        function bit upcoming_cell(output logic [TCHAN_W-1:0] chan,
                                   output logic [ROW_W-1:0] row);
            int unsigned packet;
            int unsigned in_packet;
            int unsigned k;
            int unsigned j;
            chan = '0;
            row = '0;
            if (frame_pos >= FRAME_LEN)
                return 1'b0;
            packet = frame_pos / PACKET_LEN;
            in_packet = frame_pos % PACKET_LEN;
            if (in_packet < HEADER_BYTES_DEF)
                return 1'b0;
            k = packet / 2;
            j = (in_packet - HEADER_BYTES_DEF) / 2 + (packet % 2) * HALF_CELLS;
            chan = TCHAN_W'(k);
            row = ROW_W'((((k % 2 == 1) ? stop_odd : stop_even) + 1 + j) % CELLS_DEF);
            return 1'b1;
        endfunction

        function void complain(string what, int want, int got);
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
        endfunction

        function void match_sample(logic [CHANNEL_W-1:0] channel, logic [INDEX_W-1:0] index,
                                   logic [VALUE_W-1:0] value);
            corrected_sample_t want;
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: unexpected sample expected none actual ch %0d index %0d value %0d",
                             $time, channel, index, value);
                return;
            end
            want = expected_samples.pop_front();
            if (channel !== want.channel)
                complain("out_channel", want.channel, channel);
            if (index !== want.index)
                complain("sample_index", want.index, index);
            if (value !== want.value)
                complain("corrected_value", want.value, value);
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic                       command = CMD_FRAME;
    logic                       frame_start = 1'b0;
    logic [BYTE_W-1:0]          frame_byte = '0;
    logic [ROW_W-1:0]           table_row = '0;
    logic [TCHAN_W-1:0]         table_channel = '0;
    logic signed [OFFSET_W-1:0] table_offset = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic [CHANNEL_W-1:0]       out_channel;
    logic [INDEX_W-1:0]         sample_index;
    logic [VALUE_W-1:0]         corrected_value;

    bit                 steady = 1'b0;
    int unsigned        items_sent = 0;
    int unsigned        quiet_cycles = 0;
    cell_offset_tracker tracker = new();

    waveform_frame_cell_offset_correct dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .command         (command),
        .frame_start     (frame_start),
        .frame_byte      (frame_byte),
        .table_row       (table_row),
        .table_channel   (table_channel),
        .table_offset    (table_offset),
        .empty           (empty),
        .pop             (pop),
        .out_channel     (out_channel),
        .sample_index    (sample_index),
        .corrected_value (corrected_value)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: check each popped sample, then pick next cycle's pop.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                tracker.match_sample(out_channel, sample_index, corrected_value);
            pop <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pop && !empty) || (push && !full))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic signed [OFFSET_W-1:0] random_offset();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return OFFSET_W'($urandom);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] random_data_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // Hold the transaction until accepted, then note it and maybe idle.
    task automatic send(input logic cmd, input logic start, input logic [BYTE_W-1:0] data_byte,
                        input logic [ROW_W-1:0] row, input logic [TCHAN_W-1:0] chan,
                        input logic signed [OFFSET_W-1:0] offset);
        command       <= cmd;
        frame_start   <= start;
        frame_byte    <= data_byte;
        table_row     <= row;
        table_channel <= chan;
        table_offset  <= offset;
        push          <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tracker.take_transaction(cmd, start, data_byte, row, chan, offset);
        items_sent++;
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    // Unused fields carry junk so that decoding is exercised.
    task automatic write_offset(input logic [ROW_W-1:0] row, input logic [TCHAN_W-1:0] chan,
                                input logic signed [OFFSET_W-1:0] offset);
        send(CMD_TABLE, 1'($urandom_range(1)), BYTE_W'($urandom), row, chan, offset);
    endtask

    task automatic feed_byte(input logic start, input logic [BYTE_W-1:0] data_byte);
        send(CMD_FRAME, start, data_byte, ROW_W'($urandom), TCHAN_W'($urandom),
             OFFSET_W'($urandom));
    endtask

    task automatic feed_frame(input int len);
        logic [TCHAN_W-1:0] chan;
        logic [ROW_W-1:0]   row;
        for (int n = 0; n < len; n++)
        begin
            if ($urandom_range(99) < 3)
            begin
                // in half of these writes, rewrite the very cell the next sample reads
                if ($urandom_range(1) == 1 && tracker.upcoming_cell(chan, row))
                    write_offset(row, chan, random_offset());
                else
                    write_offset(ROW_W'($urandom), TCHAN_W'($urandom), random_offset());
            end
            // load the cell the next sample reads before its first use
            if (n != 0 && tracker.upcoming_cell(chan, row) && !tracker.is_loaded(chan, row))
                write_offset(row, chan, random_offset());
            feed_byte(n == 0, random_data_byte());
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (tracker.waiting() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int pick;
        int len;
        int room;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner samples: clamp to zero, largest value, write just before its read
        write_offset(10'd0, 4'd0, 16'sh7FFF);
        write_offset(10'd1, 4'd0, 16'sh8000);
        write_offset(10'd3, 4'd0, 16'shFFFF);
        feed_byte(1'b1, 8'hA5);
        feed_byte(1'b0, 8'h5A);
        feed_byte(1'b0, 8'hFF);
        feed_byte(1'b0, 8'h00);
        feed_byte(1'b0, 8'h03);     // even stop cell 0x03FF wraps the first row to 0
        feed_byte(1'b0, 8'hFF);
        feed_byte(1'b0, 8'hFF);     // odd stop cell 0xFFFF
        feed_byte(1'b0, 8'hFF);
        feed_byte(1'b0, 8'h00);
        feed_byte(1'b0, 8'h00);
        feed_byte(1'b0, 8'hFF);
        feed_byte(1'b0, 8'hFF);
        send(CMD_TABLE, 1'b1, 8'hC3, 10'd2, 4'd0, 16'sh1234);
        feed_byte(1'b0, 8'h80);
        feed_byte(1'b0, 8'h00);
        feed_byte(1'b0, 8'h7F);
        feed_byte(1'b0, 8'hFF);
        feed_byte(1'b1, 8'h00);     // restart in mid frame
        feed_byte(1'b0, 8'h11);
        wait_drained();

        while (items_sent < RANDOM_ITEMS)
        begin
            steady = (items_sent >= 500 && items_sent < 800);
            pick = $urandom_range(99);
            if (pick < 8)
                len = $urandom_range(1, HEADER_BYTES_DEF - 1);
            else if (pick < 75)
                len = $urandom_range(HEADER_BYTES_DEF, 80);
            else
                len = $urandom_range(80, 1400);
            room = RANDOM_ITEMS - items_sent;
            if (len > room)
                len = room;
            feed_frame(len);
        end
        steady = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (tracker.mismatches == 0 && tracker.waiting() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
